// ----- design/prq_pkg.sv -----
// Shared constants, codes and word types for the packet ring queue.
`timescale 1ns / 1ps

package prq_pkg;

    localparam int QUEUE_SLOTS  = 8;
    localparam int PACKET_BYTES = 64;

    localparam int SLOT_W  = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
    localparam int BYTE_W  = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
    localparam int ADDR_W  = SLOT_W + BYTE_W;
    localparam int FILL_W  = $clog2(PACKET_BYTES + 1);
    localparam int HELD_W  = $clog2(QUEUE_SLOTS + 1);
    localparam int SIZE_W  = 7;
    localparam int QCNT_W  = 4;
    localparam int TOTAL_W = 32;

    // item kinds
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_ERROR = 2'd1;
    localparam logic [1:0] KIND_POLL  = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    // result status codes
    localparam logic [1:0] STAT_PACKET = 2'd0;
    localparam logic [1:0] STAT_EMPTY  = 2'd1;
    localparam logic [1:0] STAT_ERROR  = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         data_byte;
        logic               has_byte;
        logic               last_in;
        logic signed [15:0] rssi_in;
        logic signed [7:0]  snr_in;
    } item_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [7:0]          data_out;
        logic [SIZE_W-1:0]   packet_size;
        logic signed [15:0]  rssi_out;
        logic signed [7:0]   snr_out;
        logic                last_out;
        logic [QCNT_W-1:0]   queued_count;
        logic [TOTAL_W-1:0]  dropped_count;
        logic [TOTAL_W-1:0]  received_count;
        logic [TOTAL_W-1:0]  error_count;
    } result_t;

    typedef struct packed {
        logic [FILL_W-1:0]  size;
        logic signed [15:0] rssi;
        logic signed [7:0]  snr;
    } meta_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } byte_wr_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        meta_t             meta;
    } meta_wr_t;

    typedef struct packed {
        logic              byte_en;
        logic [ADDR_W-1:0] byte_addr;
        logic              meta_en;
        logic [SLOT_W-1:0] meta_slot;
    } store_rd_t;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] i);
        logic [SLOT_W-1:0] r;
        if (i == SLOT_W'(QUEUE_SLOTS - 1))
            r = '0;
        else
            r = i + SLOT_W'(1);
        return r;
    endfunction

endpackage

// ----- design/prq_store.sv -----
// Payload byte memory and per-slot metadata memory, registered reads.
`timescale 1ns / 1ps

module prq_store (
    input  logic               clk,
    input  prq_pkg::byte_wr_t  byte_wr,
    input  prq_pkg::meta_wr_t  meta_wr,
    input  prq_pkg::store_rd_t rd,
    output logic [7:0]         byte_q,
    output prq_pkg::meta_t     meta_q
);
    import prq_pkg::*;

    logic [7:0] byte_mem [QUEUE_SLOTS << BYTE_W];
    meta_t      meta_mem [QUEUE_SLOTS];

    always_ff @(posedge clk)
    begin
        if (byte_wr.en)
        begin
            byte_mem[byte_wr.addr] <= byte_wr.data;
        end
        if (rd.byte_en)
        begin
            byte_q <= byte_mem[rd.byte_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (meta_wr.en)
        begin
            meta_mem[meta_wr.slot] <= meta_wr.meta;
        end
        if (rd.meta_en)
        begin
            meta_q <= meta_mem[rd.meta_slot];
        end
    end

endmodule

// ----- design/packet_ring_queue_drop_oldest.sv -----
// Top level: packet ring queue that drops the oldest packet when full.
`timescale 1ns / 1ps

// A word is taken when start is high and busy is low. Arrival, error and clear
// words give no result; the block is ready again in the next cycle. A poll on
// an empty queue gives its single result in the cycle after it is taken, without
// raising busy. A poll on a queued packet holds busy while it streams its bytes
// and places one result per cycle on the result port, starting once the payload
// memory read register and then the result register have been loaded, paced by
// the one read port of the payload memory (one byte per cycle, registered read).
// result_valid marks each result for exactly one cycle; the receiver must take it
// then. A write to the suppress register is taken at any edge where cfg_write is high.
module packet_ring_queue_drop_oldest (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  prq_pkg::item_t   item,
    output logic             busy,
    output logic             result_valid,
    output prq_pkg::result_t result,
    input  logic             cfg_write,
    input  logic             cfg_data
);
    import prq_pkg::*;

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_STREAM = 1'b1;

    logic               state_reg,     state_next;
    logic               suppress_reg;
    logic [SLOT_W-1:0]  head_reg,      head_next;
    logic [SLOT_W-1:0]  tail_reg,      tail_next;
    logic [HELD_W-1:0]  held_reg,      held_next;
    logic               pending_reg,   pending_next;
    logic [FILL_W-1:0]  fill_reg,      fill_next;
    logic               mid_reg,       mid_next;
    logic [TOTAL_W-1:0] dropped_reg,   dropped_next;
    logic [TOTAL_W-1:0] received_reg,  received_next;
    logic [TOTAL_W-1:0] errors_reg,    errors_next;
    logic [SLOT_W-1:0]  poll_slot_reg, poll_slot_next;
    logic [FILL_W-1:0]  rd_idx_reg,    rd_idx_next;
    logic               res_valid_reg, res_valid_next;
    result_t            res_reg,       res_next;

    byte_wr_t   byte_wr;
    meta_wr_t   meta_wr;
    store_rd_t  rd;
    logic [7:0] byte_q;
    meta_t      meta_q;

    logic              accept;
    logic              drop;
    logic [HELD_W-1:0] held_base;
    logic [FILL_W-1:0] fill_base;
    logic              take_byte;
    logic [FILL_W-1:0] fill_new;
    logic [FILL_W-1:0] stream_size;
    logic              stream_last;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    prq_store u_store (
        .clk     (clk),
        .byte_wr (byte_wr),
        .meta_wr (meta_wr),
        .rd      (rd),
        .byte_q  (byte_q),
        .meta_q  (meta_q)
    );

    // arrival path
    always_comb
    begin
        drop      = !mid_reg && (held_reg >= HELD_W'(QUEUE_SLOTS));
        held_base = drop ? (held_reg - HELD_W'(1)) : held_reg;
        fill_base = mid_reg ? fill_reg : '0;
        take_byte = item.has_byte && (fill_base < FILL_W'(PACKET_BYTES));
        fill_new  = fill_base + FILL_W'(take_byte);
    end

    // streaming view of the polled slot
    always_comb
    begin
        stream_size = (meta_q.size > FILL_W'(PACKET_BYTES)) ? FILL_W'(PACKET_BYTES)
                                                           : meta_q.size;
        stream_last = (stream_size == '0) || (rd_idx_reg + FILL_W'(1) == stream_size);
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        held_next      = held_reg;
        pending_next   = pending_reg;
        fill_next      = fill_reg;
        mid_next       = mid_reg;
        dropped_next   = dropped_reg;
        received_next  = received_reg;
        errors_next    = errors_reg;
        poll_slot_next = poll_slot_reg;
        rd_idx_next    = rd_idx_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;

        byte_wr.en     = 1'b0;
        byte_wr.addr   = {head_reg, fill_base[BYTE_W-1:0]};
        byte_wr.data   = item.data_byte;
        meta_wr.en     = 1'b0;
        meta_wr.slot   = head_reg;
        meta_wr.meta   = '{size: fill_new, rssi: item.rssi_in, snr: item.snr_in};
        rd.byte_en     = 1'b0;
        rd.byte_addr   = {tail_reg, BYTE_W'(0)};
        rd.meta_en     = 1'b0;
        rd.meta_slot   = tail_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (item.kind)
                        KIND_BYTE:
                        begin
                            if (!suppress_reg)
                            begin
                                if (drop)
                                begin
                                    tail_next    = next_slot(tail_reg);
                                    dropped_next = dropped_reg + TOTAL_W'(1);
                                end
                                held_next  = held_base;
                                byte_wr.en = take_byte;
                                if (item.last_in)
                                begin
                                    meta_wr.en    = 1'b1;
                                    head_next     = next_slot(head_reg);
                                    held_next     = held_base + HELD_W'(1);
                                    received_next = received_reg + TOTAL_W'(1);
                                    mid_next      = 1'b0;
                                    fill_next     = '0;
                                end
                                else
                                begin
                                    mid_next  = 1'b1;
                                    fill_next = fill_new;
                                end
                            end
                        end
                        KIND_ERROR:
                        begin
                            if (!suppress_reg)
                            begin
                                errors_next  = errors_reg + TOTAL_W'(1);
                                pending_next = 1'b1;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            head_next    = '0;
                            tail_next    = '0;
                            held_next    = '0;
                            pending_next = 1'b0;
                            mid_next     = 1'b0;
                            fill_next    = '0;
                        end
                        KIND_POLL:
                        begin
                            if (held_reg != '0)
                            begin
                                rd.byte_en     = 1'b1;
                                rd.meta_en     = 1'b1;
                                poll_slot_next = tail_reg;
                                rd_idx_next    = '0;
                                tail_next      = next_slot(tail_reg);
                                held_next      = held_reg - HELD_W'(1);
                                state_next     = ST_STREAM;
                            end
                            else
                            begin
                                res_valid_next          = 1'b1;
                                res_next                = '0;
                                res_next.status         = pending_reg ? STAT_ERROR
                                                                      : STAT_EMPTY;
                                res_next.last_out       = 1'b1;
                                res_next.queued_count   = QCNT_W'(held_reg);
                                res_next.dropped_count  = dropped_reg;
                                res_next.received_count = received_reg;
                                res_next.error_count    = errors_reg;
                                pending_next            = 1'b0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_STREAM:
            begin
                // byte_q holds byte rd_idx_reg; fetch the one after it
                rd.byte_en              = !stream_last;
                rd.byte_addr            = {poll_slot_reg,
                                           BYTE_W'(rd_idx_reg + FILL_W'(1))};
                rd_idx_next             = rd_idx_reg + FILL_W'(1);
                res_valid_next          = 1'b1;
                res_next.status         = STAT_PACKET;
                res_next.data_out       = (stream_size == '0) ? 8'd0 : byte_q;
                res_next.packet_size    = SIZE_W'(stream_size);
                res_next.rssi_out       = meta_q.rssi;
                res_next.snr_out        = meta_q.snr;
                res_next.last_out       = stream_last;
                res_next.queued_count   = QCNT_W'(held_reg);
                res_next.dropped_count  = dropped_reg;
                res_next.received_count = received_reg;
                res_next.error_count    = errors_reg;
                if (stream_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            suppress_reg  <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            held_reg      <= '0;
            pending_reg   <= 1'b0;
            fill_reg      <= '0;
            mid_reg       <= 1'b0;
            dropped_reg   <= '0;
            received_reg  <= '0;
            errors_reg    <= '0;
            rd_idx_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_write)
            begin
                suppress_reg <= cfg_data;
            end
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            held_reg      <= held_next;
            pending_reg   <= pending_next;
            fill_reg      <= fill_next;
            mid_reg       <= mid_next;
            dropped_reg   <= dropped_next;
            received_reg  <= received_next;
            errors_reg    <= errors_next;
            rd_idx_reg    <= rd_idx_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        poll_slot_reg <= poll_slot_next;
        res_reg       <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

`ifndef SYNTHESIS
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= HELD_W'(QUEUE_SLOTS))
        else $error("held packet count above ring depth");

    a_ring_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (held_reg == '0 || held_reg == HELD_W'(QUEUE_SLOTS)) |-> head_reg == tail_reg)
        else $error("head and tail disagree with held count");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(PACKET_BYTES))
        else $error("fill index past slot capacity");

    a_stream_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STREAM) |=> res_valid_reg)
        else $error("streaming cycle gave no result");

    a_single_status: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.status != STAT_PACKET) |-> res_reg.last_out)
        else $error("empty or error report not marked last");
`endif

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the packet ring queue: directed words, then random traffic.
`timescale 1ns / 1ps

module tb_top;
    import prq_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 8;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    item_t   item = '0;
    logic    busy;
    logic    result_valid;
    result_t result;
    logic    cfg_write = 1'b0;
    logic    cfg_data = 1'b0;

    packet_ring_queue_drop_oldest u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    item_t   pending_words[$];
    result_t expected_words[$];
    int      idle_pct = 0;
    int      n_words = 0;
    int      n_results = 0;
    int      n_mismatch = 0;

    // shadow copy of the ring
    logic [7:0]         ring_bytes[QUEUE_SLOTS][PACKET_BYTES];
    int                 ring_size[QUEUE_SLOTS];
    logic signed [15:0] ring_rssi[QUEUE_SLOTS];
    logic signed [7:0]  ring_snr[QUEUE_SLOTS];
    int                 ring_head = 0;
    int                 ring_tail = 0;
    int                 ring_held = 0;
    int                 fill_ptr = 0;
    logic               in_packet = 1'b0;
    logic               err_flag = 1'b0;
    logic               suppress_on = 1'b0;
    logic [31:0]        drop_total = '0;
    logic [31:0]        recv_total = '0;
    logic [31:0]        err_total = '0;

    task automatic push_result(input logic [1:0] st, input logic [7:0] d, input int sz,
                               input logic signed [15:0] rs, input logic signed [7:0] sn,
                               input logic lst);
        result_t r;
        r.status         = st;
        r.data_out       = d;
        r.packet_size    = SIZE_W'(sz);
        r.rssi_out       = rs;
        r.snr_out        = sn;
        r.last_out       = lst;
        r.queued_count   = QCNT_W'(ring_held);
        r.dropped_count  = drop_total;
        r.received_count = recv_total;
        r.error_count    = err_total;
        expected_words.push_back(r);
    endtask

    task automatic predict_word(input item_t w);
        int t;
        case (w.kind)
            KIND_BYTE:
                if (!suppress_on) begin
                    if (!in_packet) begin
                        // ring full at first byte: oldest packet goes
                        if (ring_held >= QUEUE_SLOTS) begin
                            ring_tail = (ring_tail + 1) % QUEUE_SLOTS;
                            ring_held--;
                            drop_total++;
                        end
                        in_packet = 1'b1;
                        fill_ptr = 0;
                    end
                    if (w.has_byte && fill_ptr < PACKET_BYTES) begin
                        ring_bytes[ring_head][fill_ptr] = w.data_byte;
                        fill_ptr++;
                    end
                    if (w.last_in) begin
                        ring_size[ring_head] = fill_ptr;
                        ring_rssi[ring_head] = w.rssi_in;
                        ring_snr[ring_head]  = w.snr_in;
                        ring_head = (ring_head + 1) % QUEUE_SLOTS;
                        ring_held++;
                        recv_total++;
                        in_packet = 1'b0;
                        fill_ptr = 0;
                    end
                end
            KIND_ERROR:
                if (!suppress_on) begin
                    err_total++;
                    err_flag = 1'b1;
                end
            KIND_CLEAR: begin
                ring_head = 0;
                ring_tail = 0;
                ring_held = 0;
                err_flag  = 1'b0;
                in_packet = 1'b0;
                fill_ptr  = 0;
            end
            default: begin
                if (ring_held > 0) begin
                    t = ring_tail;
                    ring_tail = (ring_tail + 1) % QUEUE_SLOTS;
                    ring_held--;
                    if (ring_size[t] == 0)
                        push_result(STAT_PACKET, 8'h00, 0, ring_rssi[t], ring_snr[t], 1'b1);
                    else
                        for (int i = 0; i < ring_size[t]; i++)
                            push_result(STAT_PACKET, ring_bytes[t][i], ring_size[t],
                                        ring_rssi[t], ring_snr[t], i == ring_size[t] - 1);
                end
                else if (err_flag) begin
                    err_flag = 1'b0;
                    push_result(STAT_ERROR, 8'h00, 0, 16'sd0, 8'sd0, 1'b1);
                end
                else begin
                    push_result(STAT_EMPTY, 8'h00, 0, 16'sd0, 8'sd0, 1'b1);
                end
            end
        endcase
    endtask

    // driver: a word stays on the port until taken
    always @(posedge clk) begin
        if (!rst_n) begin
            start <= 1'b0;
        end
        else begin
            if (start && !busy) begin
                predict_word(item);
                n_words++;
            end
            if (!start || !busy) begin
                if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    item  <= pending_words.pop_front();
                    start <= 1'b1;
                end
                else begin
                    start <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string fname, input logic [31:0] e, input logic [31:0] a);
        if (e !== a) begin
            n_mismatch++;
            if (n_mismatch <= 10)
                $display("mismatch at %0t on result %0d, %s: expected %0h, got %0h",
                         $realtime, n_results, fname, e, a);
        end
    endtask

    // monitor
    always @(posedge clk) begin : monitor
        result_t e;
        if (rst_n && result_valid) begin
            if (expected_words.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result at %0t: %p", $realtime, result);
            end
            else begin
                e = expected_words.pop_front();
                check_field("status", 32'(e.status), 32'(result.status));
                check_field("data_out", 32'(e.data_out), 32'(result.data_out));
                check_field("packet_size", 32'(e.packet_size), 32'(result.packet_size));
                check_field("rssi_out", 32'($unsigned(e.rssi_out)),
                            32'($unsigned(result.rssi_out)));
                check_field("snr_out", 32'($unsigned(e.snr_out)),
                            32'($unsigned(result.snr_out)));
                check_field("last_out", 32'(e.last_out), 32'(result.last_out));
                check_field("queued_count", 32'(e.queued_count), 32'(result.queued_count));
                check_field("dropped_count", e.dropped_count, result.dropped_count);
                check_field("received_count", e.received_count, result.received_count);
                check_field("error_count", e.error_count, result.error_count);
                n_results++;
            end
        end
    end

    // watchdog: cycles with neither a word taken nor a result seen
    int idle_cycles = 0;
    always @(posedge clk) begin
        if ((start && !busy) || result_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d quiet cycles", WATCHDOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic push_word(input logic [1:0] k, input logic [7:0] d, input logic hb,
                             input logic lst, input logic signed [15:0] rs,
                             input logic signed [7:0] sn);
        item_t w;
        w.kind      = k;
        w.data_byte = d;
        w.has_byte  = hb;
        w.last_in   = lst;
        w.rssi_in   = rs;
        w.snr_in    = sn;
        pending_words.push_back(w);
    endtask

    task automatic push_ctl(input logic [1:0] k);
        push_word(k, 8'($urandom), 1'($urandom), 1'($urandom), 16'($urandom), 8'($urandom));
    endtask

    task automatic queue_packet(input int len);
        logic split;
        split = (len == 0) || ($urandom_range(3) == 0);
        for (int i = 0; i < len; i++)
            push_word(KIND_BYTE, 8'($urandom), 1'b1, !split && i == len - 1,
                      16'($urandom), 8'($urandom));
        // trailing empty word commits the packet
        if (split)
            push_word(KIND_BYTE, 8'($urandom), 1'b0, 1'b1, 16'($urandom), 8'($urandom));
    endtask

    task automatic queue_random(input int target);
        int cnt;
        int n0;
        int pick;
        cnt = 0;
        while (cnt < target) begin
            n0 = pending_words.size();
            pick = $urandom_range(99);
            if (pick < 40) begin
                pick = $urandom_range(99);
                if (pick < 85)
                    queue_packet($urandom_range(6));
                else if (pick < 97)
                    queue_packet($urandom_range(7, 20));
                else
                    queue_packet($urandom_range(PACKET_BYTES - 4, PACKET_BYTES + 6));
            end
            else if (pick < 70)
                push_ctl(KIND_POLL);
            else if (pick < 80)
                push_ctl(KIND_ERROR);
            else if (pick < 83)
                push_ctl(KIND_CLEAR);
            else
                push_ctl(2'($urandom));
            cnt += pending_words.size() - n0;
        end
    endtask

    task automatic settle();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || start || expected_words.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_suppress(input logic v);
        settle();
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        suppress_on = v;
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        set_suppress(1'b0);

        // directed: empty, error reporting, extremes, clear, overwrite
        idle_pct = 16;
        push_ctl(KIND_POLL);
        push_ctl(KIND_ERROR);
        push_ctl(KIND_POLL);
        push_ctl(KIND_POLL);
        push_word(KIND_BYTE, 8'($urandom), 1'b0, 1'b1, 16'sh7FFF, 8'sh7F);
        push_word(KIND_BYTE, 8'h00, 1'b1, 1'b0, 16'($urandom), 8'($urandom));
        push_word(KIND_BYTE, 8'hFF, 1'b1, 1'b1, 16'sh8000, 8'sh80);
        push_ctl(KIND_ERROR);
        push_ctl(KIND_POLL);
        push_ctl(KIND_POLL);
        push_ctl(KIND_POLL);
        push_word(KIND_BYTE, 8'h11, 1'b1, 1'b0, 16'($urandom), 8'($urandom));
        push_ctl(KIND_ERROR);
        push_ctl(KIND_CLEAR);
        push_ctl(KIND_POLL);
        repeat (QUEUE_SLOTS + 1)
            push_word(KIND_BYTE, 8'($urandom), 1'b0, 1'b1, 16'($urandom), 8'($urandom));
        push_ctl(KIND_POLL);
        push_ctl(KIND_CLEAR);
        // partial packet, then suppression across it
        push_word(KIND_BYTE, 8'h5A, 1'b1, 1'b0, 16'($urandom), 8'($urandom));
        push_word(KIND_BYTE, 8'hA5, 1'b1, 1'b0, 16'($urandom), 8'($urandom));
        set_suppress(1'b1);
        push_word(KIND_BYTE, 8'h3C, 1'b1, 1'b1, 16'($urandom), 8'($urandom));
        push_ctl(KIND_ERROR);
        push_ctl(KIND_POLL);
        set_suppress(1'b0);
        push_word(KIND_BYTE, 8'hC3, 1'b1, 1'b1, 16'($urandom), 8'($urandom));
        push_ctl(KIND_POLL);
        push_ctl(KIND_POLL);

        // random traffic
        idle_pct = 0;
        settle();
        queue_random(45);
        set_suppress(1'b1);
        idle_pct = 51;
        queue_random(15);
        set_suppress(1'b0);
        queue_random(45);
        settle();
        idle_pct = 16;
        queue_random(30);
        settle();

        $display("words taken %0d, results checked %0d, suppress set 0 and 1",
                 n_words, n_results);
        $display("packets received %0d, dropped %0d, error events %0d",
                 recv_total, drop_total, err_total);
        if (n_mismatch == 0 && expected_words.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
